[hdl/xor_checked_frame_decoder_top_macros.svh]
// Assertion macros shared by the frame decoder checkers.
`ifndef XOR_CHECKED_FRAME_DECODER_TOP_MACROS_SVH
`define XOR_CHECKED_FRAME_DECODER_TOP_MACROS_SVH

// A property that must hold in the same cycle as its trigger.
`define XCFD_ASSERT_SAME(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

// A property that must hold in the cycle after its trigger.
`define XCFD_ASSERT_NEXT(lbl, trig, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

[hdl/xcfd_pkg.sv]
// Shared types and constants for the XOR checked frame decoder.
`default_nettype none
package xcfd_pkg;

	localparam logic [7:0]  START_BYTE    = 8'hFE;
	localparam logic [15:0] BAD_SUM_CODE  = 16'h0013;
	localparam logic [15:0] LENGTH_LIMIT  = 16'd1024;
	localparam logic [10:0] MAX_LEN_RESET = 11'd128;
	localparam int          QUEUE_DEPTH   = 4;

	// Work that the parser hands to the result stage for one accepted byte.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_HDR   = 2'd1,
		OP_DATA  = 2'd2,
		OP_SUM   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [15:0] func;
		logic [10:0] len;
		logic [9:0]  idx;
	} q_entry_t;

endpackage
`default_nettype wire

[hdl/xcfd_front.sv]
// Frame parser: tracks the frame layout and classifies each received byte.
`default_nettype none
module xcfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_wr_en,
	input  logic [10:0]        cfg_wr_data,
	output logic               q_wr,
	output xcfd_pkg::q_entry_t q_entry
);

	typedef enum logic [7:0] {
		ST_HUNT    = 8'b0000_0001,
		ST_FUNC_HI = 8'b0000_0010,
		ST_FUNC_LO = 8'b0000_0100,
		ST_LEN_HI  = 8'b0000_1000,
		ST_LEN_LO  = 8'b0001_0000,
		ST_DATA    = 8'b0010_0000,
		ST_SUM     = 8'b0100_0000,
		ST_DROP    = 8'b1000_0000
	} state_t;

	state_t      state_q, state_d;
	logic [15:0] func_q, func_d;
	logic [15:0] len_q, len_d;
	logic [10:0] count_q, count_d;
	logic [10:0] max_len_q;
	logic [15:0] len_full;
	logic [10:0] count_inc;

	always_comb begin
		state_d   = state_q;
		func_d    = func_q;
		len_d     = len_q;
		count_d   = count_q;
		q_wr      = 1'b0;
		len_full  = {len_q[15:8], rx_byte};
		count_inc = count_q + 11'd1;

		q_entry.op   = xcfd_pkg::OP_HDR;
		q_entry.data = rx_byte;
		q_entry.func = func_q;
		q_entry.len  = len_q[10:0];
		q_entry.idx  = count_q[9:0];

		if (accept) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte == xcfd_pkg::START_BYTE) begin
						q_entry.op = xcfd_pkg::OP_START;
						q_wr       = 1'b1;
						state_d    = ST_FUNC_HI;
					end
				end
				ST_FUNC_HI: begin
					func_d  = {rx_byte, 8'h00};
					q_wr    = 1'b1;
					state_d = ST_FUNC_LO;
				end
				ST_FUNC_LO: begin
					func_d  = {func_q[15:8], rx_byte};
					q_wr    = 1'b1;
					state_d = ST_LEN_HI;
				end
				ST_LEN_HI: begin
					len_d   = {rx_byte, 8'h00};
					q_wr    = 1'b1;
					state_d = ST_LEN_LO;
				end
				ST_LEN_LO: begin
					len_d   = len_full;
					count_d = '0;
					q_wr    = 1'b1;
					// An oversized frame eats one more byte and then hunts again.
					if (len_full > {5'b0, max_len_q} || len_full > xcfd_pkg::LENGTH_LIMIT) begin
						state_d = ST_DROP;
					end else if (len_full == 16'd0) begin
						state_d = ST_SUM;
					end else begin
						state_d = ST_DATA;
					end
				end
				ST_DATA: begin
					q_entry.op = xcfd_pkg::OP_DATA;
					q_wr       = 1'b1;
					if ({5'b0, count_inc} >= len_q) begin
						count_d = '0;
						state_d = ST_SUM;
					end else begin
						count_d = count_inc;
					end
				end
				ST_SUM: begin
					q_entry.op = xcfd_pkg::OP_SUM;
					q_wr       = 1'b1;
					state_d    = ST_HUNT;
				end
				ST_DROP: begin
					state_d = ST_HUNT;
				end
				default: begin
					state_d = ST_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			func_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			func_q  <= func_d;
			len_q   <= len_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= xcfd_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule
`default_nettype wire

[hdl/xcfd_queue.sv]
// Short queue of classified bytes between the parser and the result stage.
`default_nettype none
module xcfd_queue #(
	parameter int DEPTH = xcfd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  xcfd_pkg::q_entry_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output logic               rd_valid,
	output xcfd_pkg::q_entry_t rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	xcfd_pkg::q_entry_t mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/xcfd_back.sv]
// Result stage: keeps the running checksum and builds the result items.
`default_nettype none
module xcfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  xcfd_pkg::q_entry_t q_data,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic               kind,
	output logic [15:0]        function_code,
	output logic [10:0]        payload_length,
	output logic [9:0]         byte_index,
	output logic [7:0]         data_byte,
	output logic               checksum_ok
);

	logic        out_valid_q;
	logic [7:0]  sum_q;
	logic        kind_q;
	logic [15:0] func_q;
	logic [10:0] len_q;
	logic [9:0]  idx_q;
	logic [7:0]  data_q;
	logic        ok_q;
	logic        sum_match;
	logic        load;

	// The output register takes a new entry when it is empty or being drained.
	assign q_rd      = q_valid && (!out_valid_q || pop);
	assign sum_match = (sum_q == q_data.data);
	assign load      = q_rd && (q_data.op == xcfd_pkg::OP_DATA || q_data.op == xcfd_pkg::OP_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_rd) begin
				unique case (q_data.op)
					xcfd_pkg::OP_START: sum_q <= xcfd_pkg::START_BYTE;
					xcfd_pkg::OP_HDR:   sum_q <= sum_q ^ q_data.data;
					xcfd_pkg::OP_DATA:  sum_q <= sum_q ^ q_data.data;
					xcfd_pkg::OP_SUM:   sum_q <= sum_q;
					default:            sum_q <= sum_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			len_q <= q_data.len;
			if (q_data.op == xcfd_pkg::OP_SUM) begin
				kind_q <= 1'b1;
				func_q <= sum_match ? q_data.func : xcfd_pkg::BAD_SUM_CODE;
				idx_q  <= '0;
				data_q <= '0;
				ok_q   <= sum_match;
			end else begin
				kind_q <= 1'b0;
				func_q <= q_data.func;
				idx_q  <= q_data.idx;
				data_q <= q_data.data;
				ok_q   <= 1'b0;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign kind           = kind_q;
	assign function_code  = func_q;
	assign payload_length = len_q;
	assign byte_index     = idx_q;
	assign data_byte      = data_q;
	assign checksum_ok    = ok_q;

endmodule
`default_nettype wire

[hdl/xor_checked_frame_decoder_top.sv]
// Top level of the XOR checked frame decoder.
//
// Channel   Direction  Handshake                    Payload
// input     in         push / full                  rx_byte
// result    out        empty / pop                  kind, function_code, payload_length,
//                                                   byte_index, data_byte, checksum_ok
// config    in         cfg_wr_en (no wait)          cfg_wr_data (max_payload_length)
//
// One received byte can be transferred on every clock cycle while full is low; the
// parser updates its state and classifies the byte in the cycle of the transfer.
// A result reaches the result ports through the queue and the result register, and
// results can be taken at one per cycle while no header entries lie between them.
// The classified bytes wait in a short queue (QUEUE_DEPTH entries) in front of the
// result register; full rises only when results are not taken and that queue fills.
// Reset leaves the parser hunting for a start byte, the queue and result register
// empty, and max_payload_length at 128.
`default_nettype none
module xor_checked_frame_decoder_top #(
	parameter int QUEUE_DEPTH = xcfd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] function_code,
	output logic [10:0] payload_length,
	output logic [9:0]  byte_index,
	output logic [7:0]  data_byte,
	output logic        checksum_ok,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data
);

	logic               accept;
	logic               q_wr;
	xcfd_pkg::q_entry_t q_wr_data;
	logic               q_rd;
	logic               q_valid;
	xcfd_pkg::q_entry_t q_rd_data;

	// A byte is transferred whenever push is high and the queue has room.
	assign accept = push && !full;

	// The parser sees every transferred byte, including the ones it ignores.
	xcfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_wr        (q_wr),
		.q_entry     (q_wr_data)
	);

	// Header bytes pass through the queue too so that the checksum is kept in order.
	xcfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (q_wr_data),
		.full     (full),
		.rd_en    (q_rd),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	// The result stage folds bytes into the checksum and fills the result register.
	xcfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_data         (q_rd_data),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.kind           (kind),
		.function_code  (function_code),
		.payload_length (payload_length),
		.byte_index     (byte_index),
		.data_byte      (data_byte),
		.checksum_ok    (checksum_ok)
	);

endmodule
`default_nettype wire

[hdl/xcfd_checker.sv]
// Port level checks for the frame decoder and the bind that attaches them.
`default_nettype none
`include "xor_checked_frame_decoder_top_macros.svh"
module xcfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [15:0] function_code,
	input logic [10:0] payload_length,
	input logic [9:0]  byte_index,
	input logic [7:0]  data_byte,
	input logic        checksum_ok
);

	`XCFD_ASSERT_NEXT(a_result_holds, !empty && !pop,
		!empty && $stable(function_code) && $stable(data_byte), "waiting result changed")
	`XCFD_ASSERT_SAME(a_verdict_blank, !empty && kind,
		byte_index == 10'd0 && data_byte == 8'd0, "verdict carries payload data")
	`XCFD_ASSERT_SAME(a_payload_not_ok, !empty && !kind, !checksum_ok,
		"payload result flags a checksum")
	`XCFD_ASSERT_SAME(a_bad_sum_code, !empty && kind && !checksum_ok,
		function_code == xcfd_pkg::BAD_SUM_CODE, "failed verdict lacks error code")
	`XCFD_ASSERT_SAME(a_index_in_frame, !empty && !kind,
		{1'b0, byte_index} < payload_length, "payload index beyond frame length")

endmodule

bind xor_checked_frame_decoder_top xcfd_checker u_xcfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.kind           (kind),
	.function_code  (function_code),
	.payload_length (payload_length),
	.byte_index     (byte_index),
	.data_byte      (data_byte),
	.checksum_ok    (checksum_ok)
);
`default_nettype wire

[bench/tb_xor_checked_frame_decoder_top.sv]
// Self-checking testbench for the XOR checked frame decoder: directed table plus random frames.
`default_nettype none
module tb_xor_checked_frame_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let pass after the last expected result before the block is considered idle.
	// Header bytes cause no result but may still sit in the internal queue behind it.
	localparam int SETTLE_CYCLES   = xcfd_pkg::QUEUE_DEPTH + 4;
	// Length of the long stretch in which the result side takes nothing.
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int DIRECTED_ROWS   = 27;

	// Parser states of the local copy of the decoder.
	typedef enum logic [2:0] {
		HUNT,
		FUNC_HI,
		FUNC_LO,
		LEN_HI,
		LEN_LO,
		PAYLOAD,
		CHECK,
		DROP
	} parse_state_t;

	// One result as it appears on the result ports.
	typedef struct packed {
		logic        kind;
		logic [15:0] func;
		logic [10:0] len;
		logic [9:0]  idx;
		logic [7:0]  data;
		logic        ok;
	} frame_result_t;

	// One row of the directed table. Where typed is set, want is the result that this byte
	// must cause, written out by hand; other rows are checked against the local decoder.
	typedef struct packed {
		logic [7:0]    rx;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        kind;
	logic [15:0] function_code;
	logic [10:0] payload_length;
	logic [9:0]  byte_index;
	logic [7:0]  data_byte;
	logic        checksum_ok;
	logic        cfg_wr_en = 1'b0;
	logic [10:0] cfg_wr_data = 11'd0;

	// Local copy of the decoder state and of its one register.
	parse_state_t parse_state = HUNT;
	logic [15:0]  frame_func = 16'h0000;
	logic [15:0]  frame_len = 16'h0000;
	logic [10:0]  payload_count = 11'd0;
	logic [7:0]   running_sum = 8'h00;
	logic [10:0]  max_len_setting = xcfd_pkg::MAX_LEN_RESET;

	// Results that the decoder owes, oldest first.
	frame_result_t expected_results [$];
	stim_row_t     directed_rows [DIRECTED_ROWS];

	int mismatch_count = 0;
	// Bytes that the parser actually works on; noise while hunting is not counted.
	int parsed_bytes = 0;
	// Idling controls shared between the stimulus and the result side.
	bit sender_gapless = 1'b0;
	bit receiver_gapless = 1'b0;
	bit hold_off_request = 1'b0;

	xor_checked_frame_decoder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.function_code (function_code),
		.payload_length(payload_length),
		.byte_index    (byte_index),
		.data_byte     (data_byte),
		.checksum_ok   (checksum_ok),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// 8 ns clock period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The run is cut off here if the block stops making progress.
	initial begin
		#2_000_000;
		$display("tb_xor_checked_frame_decoder_top: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic frame_result_t payload_result(input logic [15:0] func,
			input logic [10:0] len, input logic [9:0] idx, input logic [7:0] data);
		return '{kind: 1'b0, func: func, len: len, idx: idx, data: data, ok: 1'b0};
	endfunction

	function automatic frame_result_t verdict_result(input logic [15:0] func,
			input logic [10:0] len, input logic ok);
		return '{kind: 1'b1, func: func, len: len, idx: 10'd0, data: 8'h00, ok: ok};
	endfunction

	function automatic stim_row_t plain_row(input logic [7:0] rx);
		return '{rx: rx, typed: 1'b0, want: '0};
	endfunction

	function automatic stim_row_t checked_row(input logic [7:0] rx, input frame_result_t want);
		return '{rx: rx, typed: 1'b1, want: want};
	endfunction

	// Largest payload length that the parser takes under the current register value.
	function automatic int accept_cap();
		return (max_len_setting > xcfd_pkg::LENGTH_LIMIT) ? int'(xcfd_pkg::LENGTH_LIMIT)
			: int'(max_len_setting);
	endfunction

	// Advances the local decoder by one received byte and returns the result it causes.
	task automatic decode_byte(input logic [7:0] b, output bit produced,
			output frame_result_t res);
		produced = 1'b0;
		res = '0;
		if (!(parse_state == HUNT && b != xcfd_pkg::START_BYTE)) begin
			parsed_bytes++;
		end
		case (parse_state)
			HUNT: begin
				if (b == xcfd_pkg::START_BYTE) begin
					running_sum = xcfd_pkg::START_BYTE;
					parse_state = FUNC_HI;
				end
			end
			FUNC_HI: begin
				frame_func = {b, 8'h00};
				running_sum ^= b;
				parse_state = FUNC_LO;
			end
			FUNC_LO: begin
				frame_func[7:0] = b;
				running_sum ^= b;
				parse_state = LEN_HI;
			end
			LEN_HI: begin
				frame_len = {b, 8'h00};
				running_sum ^= b;
				parse_state = LEN_LO;
			end
			LEN_LO: begin
				frame_len[7:0] = b;
				running_sum ^= b;
				payload_count = 11'd0;
				if (frame_len > {5'd0, max_len_setting} ||
						frame_len > xcfd_pkg::LENGTH_LIMIT) begin
					parse_state = DROP;
				end else if (frame_len == 16'd0) begin
					parse_state = CHECK;
				end else begin
					parse_state = PAYLOAD;
				end
			end
			PAYLOAD: begin
				running_sum ^= b;
				res = payload_result(frame_func, frame_len[10:0], payload_count[9:0], b);
				produced = 1'b1;
				payload_count = payload_count + 11'd1;
				if ({5'd0, payload_count} >= frame_len) begin
					payload_count = 11'd0;
					parse_state = CHECK;
				end
			end
			CHECK: begin
				if (running_sum == b) begin
					res = verdict_result(frame_func, frame_len[10:0], 1'b1);
				end else begin
					res = verdict_result(xcfd_pkg::BAD_SUM_CODE, frame_len[10:0], 1'b0);
				end
				produced = 1'b1;
				parse_state = HUNT;
			end
			default: begin
				parse_state = HUNT;
			end
		endcase
	endtask

	// Offers one byte after a random gap and waits for its transfer. Push stays high after
	// the transfer, so back-to-back bytes go out on consecutive cycles when the next gap
	// is zero.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
			input frame_result_t want = '0);
		int gap;
		bit produced;
		frame_result_t res;
		gap = sender_gapless ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full !== 1'b0);
		decode_byte(b, produced, res);
		if (typed) begin
			expected_results.push_back(want);
		end else if (produced) begin
			expected_results.push_back(res);
		end
	endtask

	// Stops offering, waits until every expected result has been taken, then lets the
	// block settle.
	task automatic wait_until_drained();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends one frame with the given function code and length. A length above the cap is
	// followed by the single byte that the parser swallows; otherwise payload and checksum
	// follow, the checksum flipped in one bit when corrupt is set.
	task automatic send_frame(input logic [15:0] func, input int len, input bit corrupt);
		logic [15:0] len16;
		logic [7:0]  sum;
		logic [7:0]  b;
		len16 = len[15:0];
		sum = xcfd_pkg::START_BYTE ^ func[15:8] ^ func[7:0] ^ len16[15:8] ^ len16[7:0];
		send_byte(xcfd_pkg::START_BYTE);
		send_byte(func[15:8]);
		send_byte(func[7:0]);
		send_byte(len16[15:8]);
		send_byte(len16[7:0]);
		// Now and then the sender pauses mid-frame until the block has gone quiet.
		if ($urandom_range(0, 49) == 0) begin
			wait_until_drained();
		end
		if (len > accept_cap()) begin
			send_byte(8'($urandom));
		end else begin
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom);
				sum ^= b;
				send_byte(b);
			end
			if (corrupt) begin
				sum ^= 8'(1 << $urandom_range(0, 7));
			end
			send_byte(sum);
		end
	endtask

	// Mostly well-formed frames with random content and small lengths, plus noise,
	// truncated headers, zero lengths, lengths at the cap, just above it and far above it.
	task automatic send_random_frame();
		int pick;
		int cap;
		int len;
		pick = $urandom_range(0, 99);
		cap = accept_cap();
		sender_gapless = ($urandom_range(0, 4) == 0);
		if (pick < 10) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		end else if (pick < 16) begin
			send_byte(xcfd_pkg::START_BYTE);
			repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
		end else begin
			if (pick < 22) begin
				len = cap + 1;
			end else if (pick < 26) begin
				len = $urandom_range(cap + 1, 65535);
			end else if (pick < 32) begin
				len = 0;
			end else if (pick < 35 && cap <= 128) begin
				len = cap;
			end else begin
				len = (cap == 0) ? 0 : $urandom_range(1, (cap < 12) ? cap : 12);
			end
			send_frame(16'($urandom), len, $urandom_range(0, 9) == 0);
		end
	endtask

	// One phase of random traffic under a new register value. The register is written
	// only once the block has drained. At the end the parser is walked back to hunting so
	// that whatever follows starts on a frame boundary.
	task automatic run_phase(input logic [10:0] setting, input int budget,
			input bit hold_receiver);
		int stop_at;
		wait_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= setting;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len_setting = setting;
		receiver_gapless = ($urandom_range(0, 3) == 0);
		if (hold_receiver) begin
			// The result side stops taking results while a gapless frame streams in, so the
			// queue fills and full must hold the sender off.
			hold_off_request = 1'b1;
			sender_gapless = 1'b1;
			send_frame(16'($urandom), (accept_cap() < 16) ? accept_cap() : 16, 1'b0);
		end
		stop_at = parsed_bytes + budget;
		while (parsed_bytes < stop_at) send_random_frame();
		while (parse_state != HUNT) send_byte(8'($urandom_range(0, 253)));
	endtask

	// Result side: takes results after random gaps, honors a requested long hold-off, and
	// compares every transfer with the oldest expectation.
	initial begin
		frame_result_t got;
		frame_result_t want;
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
			end
			gap = receiver_gapless ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			got = '{kind: kind, func: function_code, len: payload_length, idx: byte_index,
				data: data_byte, ok: checksum_ok};
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %p", got));
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind) begin
					report_mismatch($sformatf("kind %0h, expected %0h", got.kind, want.kind));
				end
				if (got.func !== want.func) begin
					report_mismatch($sformatf("function_code %0h, expected %0h",
						got.func, want.func));
				end
				if (got.len !== want.len) begin
					report_mismatch($sformatf("payload_length %0d, expected %0d",
						got.len, want.len));
				end
				if (got.idx !== want.idx) begin
					report_mismatch($sformatf("byte_index %0d, expected %0d",
						got.idx, want.idx));
				end
				if (got.data !== want.data) begin
					report_mismatch($sformatf("data_byte %0h, expected %0h",
						got.data, want.data));
				end
				if (got.ok !== want.ok) begin
					report_mismatch($sformatf("checksum_ok %0h, expected %0h",
						got.ok, want.ok));
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then phases of random frames.
	initial begin
		directed_rows = '{
			// A stray byte while hunting is ignored.
			plain_row(8'h00),
			// Zero length with the largest function code: the checksum byte follows the
			// header directly.
			plain_row(8'hFE), plain_row(8'hFF), plain_row(8'hFF),
			plain_row(8'h00), plain_row(8'h00),
			checked_row(8'hFE, verdict_result(16'hFFFF, 11'd0, 1'b1)),
			// Wrong checksum: the verdict carries the bad checksum code.
			plain_row(8'hFE), plain_row(8'h00), plain_row(8'h00),
			plain_row(8'h00), plain_row(8'h00),
			checked_row(8'h00, verdict_result(xcfd_pkg::BAD_SUM_CODE, 11'd0, 1'b0)),
			// Two payload bytes at the extremes, then a good checksum.
			plain_row(8'hFE), plain_row(8'h80), plain_row(8'h01),
			plain_row(8'h00), plain_row(8'h02),
			checked_row(8'h00, payload_result(16'h8001, 11'd2, 10'd0, 8'h00)),
			checked_row(8'hFF, payload_result(16'h8001, 11'd2, 10'd1, 8'hFF)),
			plain_row(8'h82),
			// Length one above the reset maximum: the next byte is swallowed, even a
			// start byte, and nothing comes out.
			plain_row(8'hFE), plain_row(8'h12), plain_row(8'h34),
			plain_row(8'h00), plain_row(8'h81),
			plain_row(8'hFE)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
		end

		run_phase(11'($urandom_range(0, 2047)), 160, 1'b0);
		// A maximum of zero: only empty frames get through.
		run_phase(11'd0, 100, 1'b0);
		run_phase(11'd1, 100, 1'b0);
		run_phase(11'd1024, 180, 1'b1);
		send_frame(16'($urandom), 1025, 1'b0);
		// Register above the hard limit: the limit still caps the length, so a length one
		// above it is dropped.
		run_phase(11'd2047, 130, 1'b0);
		send_frame(16'($urandom), 1025, 1'b0);
		send_frame(16'($urandom), 65535, 1'b0);
		run_phase(11'd128, 230, 1'b1);
		run_phase(11'($urandom_range(2, 64)), 230, 1'b0);

		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_xor_checked_frame_decoder_top: PASS");
		end else begin
			$display("tb_xor_checked_frame_decoder_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
